FILE: rtl/core/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types, constants and saturation helpers for the cascade bounds fit.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int NumRegs = 7;
  localparam int IdxW    = 3;
  localparam int DistW   = 31;
  localparam int ProdW   = 48;
  localparam int SumW    = 50;

  // register indexes
  localparam logic [IdxW-1:0] RegRowXLo   = 3'd0;
  localparam logic [IdxW-1:0] RegRowXHi   = 3'd1;
  localparam logic [IdxW-1:0] RegRowYLo   = 3'd2;
  localparam logic [IdxW-1:0] RegRowYHi   = 3'd3;
  localparam logic [IdxW-1:0] RegRowZLo   = 3'd4;
  localparam logic [IdxW-1:0] RegRowZHi   = 3'd5;
  localparam logic [IdxW-1:0] RegTangents = 3'd6;

  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  localparam logic signed [32:0] PadXy    = 33'sd655360;
  localparam logic signed [32:0] PadZNear = 33'sd19660800;
  localparam logic signed [32:0] PadZFar  = 33'sd655360;

  // control word that travels with each stage
  typedef struct packed {
    logic valid;
    logic sat;
  } sbf_ctl_t;

  function automatic logic sat_ovf(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] mx;
    logic signed [SumW-1:0] mn;
    mx = SumW'(QMax);
    mn = SumW'(QMin);
    return (v > mx) || (v < mn);
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] mx;
    logic signed [SumW-1:0] mn;
    mx = SumW'(QMax);
    mn = SumW'(QMin);
    if (v > mx) return QMax;
    if (v < mn) return QMin;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/core/sbf_extent.sv
// ----------------------------------------------------------------------------
// sbf_extent
// Stage 1: slice extents from distance times tangent, plus their negations.
// ----------------------------------------------------------------------------
module sbf_extent import sbf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [DistW-1:0]         near_distance,
  input  logic [DistW-1:0]         far_distance,
  input  logic [63:0]              tangents,
  output sbf_ctl_t                 ctl,
  output logic signed [31:0]       dz [2],
  output logic signed [31:0]       ex [2],
  output logic signed [31:0]       nex [2],
  output logic signed [31:0]       ey [2],
  output logic signed [31:0]       ney [2]
);

  logic signed [31:0] th;
  logic signed [31:0] tv;
  logic signed [31:0] d_in [2];
  logic signed [31:0] ex_next [2];
  logic signed [31:0] ey_next [2];
  logic signed [31:0] nex_next [2];
  logic signed [31:0] ney_next [2];
  logic [3:0]         ovf;

  assign th = $signed(tangents[31:0]);
  assign tv = $signed(tangents[63:32]);
  assign d_in[0] = $signed({1'b0, near_distance});
  assign d_in[1] = $signed({1'b0, far_distance});

  // floored products, saturated, then negated with saturation
  always_comb begin
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    for (int f = 0; f < 2; f++) begin
      px = d_in[f] * th;
      py = d_in[f] * tv;
      sx = SumW'(px >>> 16);
      sy = SumW'(py >>> 16);
      ex_next[f]  = sat_q(sx);
      ey_next[f]  = sat_q(sy);
      ovf[2*f]    = sat_ovf(sx) || (ex_next[f] == QMin);
      ovf[2*f+1]  = sat_ovf(sy) || (ey_next[f] == QMin);
      nex_next[f] = (ex_next[f] == QMin) ? QMax : -ex_next[f];
      ney_next[f] = (ey_next[f] == QMin) ? QMax : -ey_next[f];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= in_valid;
      ctl.sat   <= |ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz   <= d_in;
      ex   <= ex_next;
      ey   <= ey_next;
      nex  <= nex_next;
      ney  <= ney_next;
    end
  end

endmodule

FILE: rtl/core/sbf_transform.sv
// ----------------------------------------------------------------------------
// sbf_transform
// Stages 2 and 3: matrix row products, then per-corner row sums.
// ----------------------------------------------------------------------------
module sbf_transform import sbf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [63:0]          rows [6],
  input  sbf_ctl_t             ctl_in,
  input  logic signed [31:0]   dz [2],
  input  logic signed [31:0]   ex [2],
  input  logic signed [31:0]   nex [2],
  input  logic signed [31:0]   ey [2],
  input  logic signed [31:0]   ney [2],
  output sbf_ctl_t             ctl,
  output logic signed [31:0]   coord [3][8]
);

  // product slots: +x, -x, +y, -y, z
  logic signed [ProdW-1:0] prod [2][3][5];
  logic signed [ProdW-1:0] prod_next [2][3][5];
  sbf_ctl_t                ctl_mid;
  logic signed [31:0]      coord_next [3][8];
  logic                    ovf_any;

  // stage 2: floored products
  always_comb begin
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [63:0] p [5];
    for (int f = 0; f < 2; f++) begin
      for (int r = 0; r < 3; r++) begin
        m0 = $signed(rows[2*r][31:0]);
        m1 = $signed(rows[2*r][63:32]);
        m2 = $signed(rows[2*r+1][31:0]);
        p[0] = m0 * ex[f];
        p[1] = m0 * nex[f];
        p[2] = m1 * ey[f];
        p[3] = m1 * ney[f];
        p[4] = m2 * dz[f];
        for (int k = 0; k < 5; k++) begin
          prod_next[f][r][k] = ProdW'(p[k] >>> 16);
        end
      end
    end
  end

  // stage 3: corner sums with the translation column
  always_comb begin
    logic signed [SumW-1:0] s;
    int f;
    ovf_any = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 8; c++) begin
        f = c / 4;
        s = SumW'(prod[f][r][(c % 2)])
          + SumW'(prod[f][r][2 + ((c / 2) % 2)])
          + SumW'(prod[f][r][4])
          + SumW'($signed(rows[2*r+1][63:32]));
        coord_next[r][c] = sat_q(s);
        ovf_any = ovf_any | sat_ovf(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid <= '0;
      ctl     <= '0;
    end else if (en) begin
      ctl_mid   <= ctl_in;
      ctl.valid <= ctl_mid.valid;
      ctl.sat   <= ctl_mid.sat | ovf_any;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= prod_next;
      coord <= coord_next;
    end
  end

endmodule

FILE: rtl/core/sbf_reduce.sv
// ----------------------------------------------------------------------------
// sbf_reduce
// Stages 4 and 5: min and max over the eight corners, then padded bounds.
// ----------------------------------------------------------------------------
module sbf_reduce import sbf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  sbf_ctl_t             ctl_in,
  input  logic signed [31:0]   coord [3][8],
  output sbf_ctl_t             ctl,
  output logic signed [31:0]   bound [6]
);

  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic signed [31:0] lo_next [3];
  logic signed [31:0] hi_next [3];
  logic signed [31:0] bound_next [6];
  logic               ovf_any;
  sbf_ctl_t           ctl_mid;

  // stage 4: extrema per axis
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_next[r] = QMax;
      hi_next[r] = QMin;
      for (int c = 0; c < 8; c++) begin
        if (coord[r][c] < lo_next[r]) lo_next[r] = coord[r][c];
        if (coord[r][c] > hi_next[r]) hi_next[r] = coord[r][c];
      end
    end
  end

  // stage 5: padding with saturation
  always_comb begin
    logic signed [SumW-1:0] s [6];
    s[0] = SumW'(lo[0]) - SumW'(PadXy);
    s[1] = SumW'(hi[0]) + SumW'(PadXy);
    s[2] = SumW'(lo[1]) - SumW'(PadXy);
    s[3] = SumW'(hi[1]) + SumW'(PadXy);
    s[4] = SumW'(lo[2]) - SumW'(PadZNear);
    s[5] = SumW'(hi[2]) + SumW'(PadZFar);
    ovf_any = 1'b0;
    for (int k = 0; k < 6; k++) begin
      bound_next[k] = sat_q(s[k]);
      ovf_any = ovf_any | sat_ovf(s[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid <= '0;
      ctl     <= '0;
    end else if (en) begin
      ctl_mid   <= ctl_in;
      ctl.valid <= ctl_mid.valid;
      ctl.sat   <= ctl_mid.sat | ovf_any;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo    <= lo_next;
      hi    <= hi_next;
      bound <= bound_next;
    end
  end

endmodule

FILE: rtl/core/shadow_cascade_bounds_fit.sv
// Throughput: one word per cycle; the five-stage pipeline advances as a unit
// and holds whenever the output word is valid and stalled.
// Reset: synchronous, clears all valid bits and the seven configuration
// registers to zero.
// ----------------------------------------------------------------------------
// shadow_cascade_bounds_fit
// Fits padded light-space bounds around one cascade slice of the view frustum.
// ----------------------------------------------------------------------------
module shadow_cascade_bounds_fit import sbf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DistW-1:0]    near_distance,
  input  logic [DistW-1:0]    far_distance,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  left_bound,
  output logic signed [31:0]  right_bound,
  output logic signed [31:0]  bottom_bound,
  output logic signed [31:0]  top_bound,
  output logic signed [31:0]  near_bound,
  output logic signed [31:0]  far_bound,
  output logic                saturated
);

  logic [63:0]        regs [NumRegs];
  logic [63:0]        rows [6];
  logic               en;
  sbf_ctl_t           ctl1;
  sbf_ctl_t           ctl3;
  sbf_ctl_t           ctl5;
  logic signed [31:0] dz [2];
  logic signed [31:0] ex [2];
  logic signed [31:0] nex [2];
  logic signed [31:0] ey [2];
  logic signed [31:0] ney [2];
  logic signed [31:0] coord [3][8];
  logic signed [31:0] bound [6];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (cfg_valid && (int'(cfg_index) < NumRegs)) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign rows[0] = regs[RegRowXLo];
  assign rows[1] = regs[RegRowXHi];
  assign rows[2] = regs[RegRowYLo];
  assign rows[3] = regs[RegRowYHi];
  assign rows[4] = regs[RegRowZLo];
  assign rows[5] = regs[RegRowZHi];

  // pipeline advance
  assign en       = !(ctl5.valid && out_stall);
  assign in_stall = !en;

  sbf_extent u_extent (
    .clk, .rst, .en, .in_valid, .near_distance, .far_distance,
    .tangents(regs[RegTangents]), .ctl(ctl1), .dz, .ex, .nex, .ey, .ney
  );

  sbf_transform u_transform (
    .clk, .rst, .en, .rows, .ctl_in(ctl1), .dz, .ex, .nex, .ey, .ney,
    .ctl(ctl3), .coord
  );

  sbf_reduce u_reduce (
    .clk, .rst, .en, .ctl_in(ctl3), .coord, .ctl(ctl5), .bound
  );

  assign out_valid    = ctl5.valid;
  assign saturated    = ctl5.sat;
  assign left_bound   = bound[0];
  assign right_bound  = bound[1];
  assign bottom_bound = bound[2];
  assign top_bound    = bound[3];
  assign near_bound   = bound[4];
  assign far_bound    = bound[5];

`ifndef SYNTH
  // bounds are ordered since min never exceeds max
  a_x_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_bound <= right_bound)) else $error("x bounds out of order");
  a_z_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (near_bound <= far_bound)) else $error("z bounds out of order");
  // a stalled result word is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(left_bound) && $stable(saturated)))
    else $error("stalled result changed");
  // input backpressure only from a stalled output word
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall)) else $error("spurious input stall");
`endif

endmodule
